FILE: sv/ber_oid_tlv_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// ber oid tlv decoder assertion macros
// Checks stay out of synthesis; the synthesis variants expand to nothing.
// ----------------------------------------------------------------------------
`ifndef BER_OID_TLV_DECODER_UNIT_ASSERT_SVH
`define BER_OID_TLV_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define BOD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bod check failed");
// consequent must hold in the cycle after the antecedent
`define BOD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bod check failed");
`else
`define BOD_ASSERT_NOW(label, ante, cons)
`define BOD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: sv/bod_pkg.sv
// ----------------------------------------------------------------------------
// bod_pkg
// Shared types and constants of the ber oid tlv decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package bod_pkg;

  localparam int unsigned MAX_LENGTH_BYTES = 4;
  localparam logic [7:0]  OID_TAG          = 8'h06;

  // x / 40 is (x >> 3) / 5, and y / 5 is (y * 0xcccccccd) >> 34 for any 32-bit y
  localparam logic [31:0] DIV5_RECIP = 32'hCCCCCCCD;
  localparam int unsigned DIV5_SHIFT = 34;

  typedef enum logic [1:0] {
    PH_TAG,
    PH_LEN,
    PH_LLEN,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    ERR_TAG      = 2'd0,
    ERR_EMPTY    = 2'd1,
    ERR_TOO_LONG = 2'd2,
    ERR_TRUNC    = 2'd3
  } err_code_t;

  // at most one queue entry per byte; a split entry yields two arc beats
  typedef struct packed {
    logic        is_error;
    logic        split;
    logic [31:0] value;
    logic        last;
    err_code_t   code;
  } res_ent_t;

endpackage

`default_nettype wire

FILE: sv/bod_front.sv
// ----------------------------------------------------------------------------
// bod_front
// Tlv parser: takes one byte per beat, tracks tag/length/content state and
// pushes at most one entry per byte into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ber_oid_tlv_decoder_unit_assert.svh"

module bod_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_buffer_end,
  input  wire logic              q_full,
  output logic                   push,
  output bod_pkg::res_ent_t      push_ent
);

  bod_pkg::phase_t    phase_r, phase_nxt;
  logic [2:0]         len_left_r, len_left_nxt;
  logic [30:0]        content_left_r, content_left_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic               first_r, first_nxt;

  logic               accept;
  logic [6:0]         len_field;
  logic [30:0]        llen_content;
  logic [2:0]         len_dec;
  logic [31:0]        acc_body;
  logic [30:0]        body_left;

  logic               err_hit;
  bod_pkg::err_code_t err_code;
  logic               trunc;
  bod_pkg::phase_t    step_phase;
  logic [2:0]         step_len;
  logic [30:0]        step_content;
  logic [31:0]        step_acc;
  logic               step_first;
  logic               arc_done;
  logic               arc_last;

  assign in_stall     = q_full;
  assign accept       = in_valid && !in_stall;
  assign len_field    = in_data_byte[6:0];
  assign llen_content = {content_left_r[22:0], in_data_byte};
  assign len_dec      = len_left_r - 3'd1;
  assign acc_body     = {acc_r[24:0], in_data_byte[6:0]};
  assign body_left    = (content_left_r == '0) ? '0 : content_left_r - 31'd1;

  // classify the byte against the current phase
  always_comb begin
    err_hit      = 1'b0;
    err_code     = bod_pkg::ERR_TAG;
    step_phase   = phase_r;
    step_len     = len_left_r;
    step_content = content_left_r;
    step_acc     = acc_r;
    step_first   = first_r;
    arc_done     = 1'b0;
    arc_last     = 1'b0;
    unique case (phase_r)
      bod_pkg::PH_TAG: begin
        if (in_data_byte != bod_pkg::OID_TAG) begin
          err_hit  = 1'b1;
          err_code = bod_pkg::ERR_TAG;
        end else begin
          step_phase = bod_pkg::PH_LEN;
        end
      end
      bod_pkg::PH_LEN: begin
        if (!in_data_byte[7]) begin
          if (in_data_byte == 8'h00) begin
            err_hit  = 1'b1;
            err_code = bod_pkg::ERR_EMPTY;
          end else begin
            step_content = 31'(in_data_byte);
            step_phase   = bod_pkg::PH_BODY;
          end
        end else if (len_field == 7'd0) begin
          // indefinite form counts as empty
          err_hit  = 1'b1;
          err_code = bod_pkg::ERR_EMPTY;
        end else if (len_field > 7'(bod_pkg::MAX_LENGTH_BYTES)) begin
          err_hit  = 1'b1;
          err_code = bod_pkg::ERR_TOO_LONG;
        end else begin
          step_len     = len_field[2:0];
          step_content = '0;
          step_phase   = bod_pkg::PH_LLEN;
        end
      end
      bod_pkg::PH_LLEN: begin
        // shifting in another byte would pass 2^31-1
        if (|content_left_r[30:23]) begin
          err_hit  = 1'b1;
          err_code = bod_pkg::ERR_TOO_LONG;
        end else begin
          step_content = llen_content;
          step_len     = len_dec;
          if (len_dec == 3'd0) begin
            if (llen_content == '0) begin
              err_hit  = 1'b1;
              err_code = bod_pkg::ERR_EMPTY;
            end else begin
              step_phase = bod_pkg::PH_BODY;
            end
          end
        end
      end
      bod_pkg::PH_BODY: begin
        step_acc     = acc_body;
        step_content = body_left;
        if (!in_data_byte[7] || body_left == '0) begin
          arc_done   = 1'b1;
          arc_last   = (body_left == '0);
          step_acc   = '0;
          step_first = 1'b0;
        end
        if (body_left == '0) begin
          step_phase   = bod_pkg::PH_TAG;
          step_len     = '0;
          step_content = '0;
          step_acc     = '0;
          step_first   = 1'b1;
        end
      end
    endcase
  end

  assign trunc = in_buffer_end && !err_hit && (step_phase != bod_pkg::PH_TAG);

  // next state
  always_comb begin
    phase_nxt        = phase_r;
    len_left_nxt     = len_left_r;
    content_left_nxt = content_left_r;
    acc_nxt          = acc_r;
    first_nxt        = first_r;
    if (accept) begin
      if (err_hit || trunc) begin
        phase_nxt        = bod_pkg::PH_TAG;
        len_left_nxt     = '0;
        content_left_nxt = '0;
        acc_nxt          = '0;
        first_nxt        = 1'b1;
      end else begin
        phase_nxt        = step_phase;
        len_left_nxt     = step_len;
        content_left_nxt = step_content;
        acc_nxt          = step_acc;
        first_nxt        = step_first;
      end
    end
  end

  // queue entry
  always_comb begin
    push              = accept && (err_hit || trunc || arc_done);
    push_ent.is_error = err_hit || trunc;
    push_ent.split    = 1'b0;
    push_ent.value    = '0;
    push_ent.last     = 1'b0;
    push_ent.code     = bod_pkg::ERR_TAG;
    priority if (err_hit) begin
      push_ent.code = err_code;
    end else if (trunc) begin
      // truncation drops any arc this byte would have closed
      push_ent.code = bod_pkg::ERR_TRUNC;
    end else begin
      push_ent.split = first_r;
      push_ent.value = acc_body;
      push_ent.last  = arc_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= bod_pkg::PH_TAG;
      len_left_r     <= '0;
      content_left_r <= '0;
      acc_r          <= '0;
      first_r        <= 1'b1;
    end else begin
      phase_r        <= phase_nxt;
      len_left_r     <= len_left_nxt;
      content_left_r <= content_left_nxt;
      acc_r          <= acc_nxt;
      first_r        <= first_nxt;
    end
  end

  `BOD_ASSERT_NEXT(a_err_back_to_tag, push && push_ent.is_error, phase_r == bod_pkg::PH_TAG)
  `BOD_ASSERT_NOW(a_body_has_content, phase_r == bod_pkg::PH_BODY, content_left_r != '0)
  `BOD_ASSERT_NOW(a_llen_count_ok, phase_r == bod_pkg::PH_LLEN,
                  (len_left_r != 3'd0) && (len_left_r <= 3'(bod_pkg::MAX_LENGTH_BYTES)))

endmodule

`default_nettype wire

FILE: sv/bod_queue.sv
// ----------------------------------------------------------------------------
// bod_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ber_oid_tlv_decoder_unit_assert.svh"

module bod_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire bod_pkg::res_ent_t push_ent,
  output logic                   full,
  input  wire logic              pop,
  output bod_pkg::res_ent_t      head_ent,
  output logic                   empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bod_pkg::res_ent_t  ent_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_ent = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `BOD_ASSERT_NOW(a_no_push_full, push, !full)
  `BOD_ASSERT_NOW(a_no_pop_empty, pop, !empty)
  `BOD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

FILE: sv/bod_back.sv
// ----------------------------------------------------------------------------
// bod_back
// Result stage: pops queue entries, splits the first subidentifier by 40
// and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bod_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bod_pkg::res_ent_t head_ent,
  input  wire logic              q_empty,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_is_error,
  output logic [31:0]            out_arc_value,
  output logic                   out_last_arc,
  output logic [1:0]             out_error_code
);

  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_second_r, s1_second_nxt;
  bod_pkg::res_ent_t  s1_ent_r;
  logic [26:0]        s1_quot_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_is_error_r;
  logic [31:0]        out_arc_value_r;
  logic               out_last_arc_r;
  logic [1:0]         out_error_code_r;

  logic [60:0]        div_prod;
  logic [31:0]        times40;
  logic [31:0]        rem;
  logic               out_free;
  logic               emit;
  logic               s1_done;

  logic               beat_is_error;
  logic [31:0]        beat_value;
  logic               beat_last;
  logic [1:0]         beat_code;

  // quotient by 40 from the queue head, registered before use
  assign div_prod = head_ent.value[31:3] * bod_pkg::DIV5_RECIP;
  assign times40  = {s1_quot_r, 5'b0} + 32'({s1_quot_r, 3'b0});
  assign rem      = s1_ent_r.value - times40;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = s1_valid_r && out_free;
  assign s1_done  = emit && (!s1_ent_r.split || s1_second_r || s1_ent_r.is_error);
  assign pop      = !q_empty && (!s1_valid_r || s1_done);

  always_comb begin
    beat_is_error = s1_ent_r.is_error;
    beat_value    = s1_ent_r.value;
    beat_last     = s1_ent_r.last;
    beat_code     = 2'(bod_pkg::ERR_TAG);
    priority if (s1_ent_r.is_error) begin
      beat_value = '0;
      beat_last  = 1'b0;
      beat_code  = 2'(s1_ent_r.code);
    end else if (s1_ent_r.split && !s1_second_r) begin
      beat_value = 32'(s1_quot_r);
      beat_last  = 1'b0;
    end else if (s1_ent_r.split) begin
      beat_value = rem;
    end else begin
      beat_value = s1_ent_r.value;
    end
  end

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_second_nxt = s1_second_r;
    if (pop) begin
      s1_valid_nxt  = 1'b1;
      s1_second_nxt = 1'b0;
    end else if (s1_done) begin
      s1_valid_nxt  = 1'b0;
      s1_second_nxt = 1'b0;
    end else if (emit) begin
      s1_second_nxt = 1'b1;
    end
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_ent_r  <= head_ent;
      s1_quot_r <= div_prod[60:bod_pkg::DIV5_SHIFT];
    end
    if (emit) begin
      out_is_error_r   <= beat_is_error;
      out_arc_value_r  <= beat_value;
      out_last_arc_r   <= beat_last;
      out_error_code_r <= beat_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_second_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s1_second_r <= s1_second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_error   = out_is_error_r;
  assign out_arc_value  = out_arc_value_r;
  assign out_last_arc   = out_last_arc_r;
  assign out_error_code = out_error_code_r;

endmodule

`default_nettype wire

FILE: sv/ber_oid_tlv_decoder_unit.sv
// A byte's result passes the queue and the s1 register before it is registered on out_.
// Throughput: one byte per cycle unless in_stall; one result per cycle unless out_stall.
// A byte that closes the first subidentifier gives two results from a single entry; the
// FIFO_DEPTH-entry queue absorbs the extra output beat before in_stall rises.
// Reset (synchronous, rst_n low): parser back to expecting a tag, queue and output empty.
// ----------------------------------------------------------------------------
// ber_oid_tlv_decoder_unit
// Ber object identifier tlv decoder: byte parser, result queue, output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ber_oid_tlv_decoder_unit #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_buffer_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_error,
  output logic [31:0]      out_arc_value,
  output logic             out_last_arc,
  output logic [1:0]       out_error_code
);

  bod_pkg::res_ent_t push_ent;
  bod_pkg::res_ent_t head_ent;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;

  bod_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_buffer_end (in_buffer_end),
    .q_full        (q_full),
    .push          (push),
    .push_ent      (push_ent)
  );

  bod_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (pop),
    .head_ent (head_ent),
    .empty    (q_empty)
  );

  bod_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_ent       (head_ent),
    .q_empty        (q_empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_is_error   (out_is_error),
    .out_arc_value  (out_arc_value),
    .out_last_arc   (out_last_arc),
    .out_error_code (out_error_code)
  );

endmodule

`default_nettype wire
